/* rtl/core/hduart_pkg.sv */
// Shared types and codes for the half-duplex UART with transmit buffer.
`default_nettype none
package hduart_pkg;

    // Event codes carried in the request tuser
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_EDGE = 2'd1;
    localparam logic [1:0] OP_PUSH = 2'd2;

    // Line state machine codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RX_START = 3'd1;
    localparam logic [2:0] PH_RX_DATA  = 3'd2;
    localparam logic [2:0] PH_TX_START = 3'd3;
    localparam logic [2:0] PH_TX_DATA  = 3'd4;

    // Bits per character and request/result bus widths
    localparam int unsigned DATA_BITS  = 8;
    localparam int unsigned S_DATA_W   = 16;
    localparam int unsigned S_USER_W   = 2;
    localparam int unsigned M_DATA_W   = 16;
    localparam int unsigned RESULT_W   = 13;

    // Request fields
    typedef struct packed {
        logic [1:0] opcode;
        logic       rx_level;
        logic [7:0] tx_byte;
    } t_request;

    // Result fields, first field in the highest bits when packed
    typedef struct packed {
        logic       timer_on;
        logic       tx_busy;
        logic       push_accepted;
        logic [7:0] rx_data;
        logic       rx_valid;
        logic       tx_line;
    } t_result;

endpackage
`default_nettype wire

/* rtl/core/half_duplex_uart_with_tx_buffer.sv */
// Top level of the half-duplex 8N1 UART with linear transmit buffer.
`default_nettype none
// Each request is one event (bit tick, receive falling edge, or transmit push) and
// yields exactly one result, registered in the output stage when the request is
// taken and held there, or in its skid slot, while the result side stalls. One
// request is taken every clock while results drain: the line state machine updates
// all its registers together, and the byte being transmitted is prefetched from the
// buffer memory so its read port never stalls the sequence. A two-slot output stage
// takes one more request after the result side stops and then holds off requests
// until a result drains. The transmit buffer holds BUFFER_DEPTH bytes; a push into a
// full buffer is dropped and reported with push_accepted low.
module half_duplex_uart_with_tx_buffer #(
    parameter int unsigned BUFFER_DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] rx_level, [8:1] tx_byte, [15:9] zero
    input  wire  [15:0] s_axis_tdata,
    // [1:0] opcode
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [0] tx_line, [1] rx_valid, [9:2] rx_data, [10] push_accepted,
    // [11] tx_busy, [12] timer_on, [15:13] zero
    output logic [15:0] m_axis_tdata
);
    import hduart_pkg::*;

    t_request req;
    t_result  core_res;
    t_result  out_res;
    logic     accept;

    assign req.opcode   = s_axis_tuser;
    assign req.rx_level = s_axis_tdata[0];
    assign req.tx_byte  = s_axis_tdata[8:1];
    assign accept       = s_axis_tvalid && s_axis_tready;

    hduart_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_req   (req),
        .o_res   (core_res)
    );

    hduart_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_res   (core_res),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (m_axis_tready)
    );

    // Pack the result and pad to whole bytes
    assign m_axis_tdata = {{(M_DATA_W - RESULT_W){1'b0}}, out_res};

endmodule
`default_nettype wire

/* rtl/core/hduart_core.sv */
// Line state machine, transmit buffer memory and result formation.
`default_nettype none
module hduart_core #(
    parameter int unsigned BUFFER_DEPTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  hduart_pkg::t_request i_req,
    output hduart_pkg::t_result  o_res
);
    import hduart_pkg::*;

    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
    localparam logic [3:0] LAST_BIT = 4'(DATA_BITS);

    logic [2:0]    r_phase, n_phase;
    logic [3:0]    r_bit, n_bit;
    logic [7:0]    r_rx, n_rx;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_sent, n_sent;
    logic          r_busy, n_busy;
    logic          r_timer, n_timer;
    logic          r_line, n_line;

    logic [7:0]    r_store [BUFFER_DEPTH];
    logic [7:0]    r_rd_data;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          rx_done;
    logic          push_ok;
    logic [2:0]    cur_phase;
    logic [2:0]    nxt_phase;
    logic [3:0]    bit_inc;
    logic [CW-1:0] sent_inc;

    assign wr_addr  = r_fill[AW-1:0];
    assign rd_addr  = (n_sent < DEPTH_C) ? n_sent[AW-1:0] : '0;
    assign bit_inc  = r_bit + 4'd1;
    assign sent_inc = (r_sent < DEPTH_C) ? (r_sent + CW'(1)) : r_sent;

    // Work out the next state for the accepted request
    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_rx      = r_rx;
        n_fill    = r_fill;
        n_sent    = r_sent;
        n_busy    = r_busy;
        n_timer   = r_timer;
        n_line    = r_line;
        wr_en     = 1'b0;
        rx_done   = 1'b0;
        push_ok   = 1'b0;
        cur_phase = r_phase;
        nxt_phase = r_phase;
        if (i_en) begin
            unique case (i_req.opcode)
                OP_TICK: begin
                    if (r_timer) begin
                        // Pending transmit takes over the line
                        if (!r_busy && (r_fill > r_sent)) begin
                            cur_phase = PH_TX_START;
                            nxt_phase = PH_TX_START;
                            n_busy    = 1'b1;
                        end
                        unique case (cur_phase)
                            PH_RX_START: begin
                                if (!i_req.rx_level) begin
                                    nxt_phase = PH_RX_DATA;
                                    n_bit     = 4'd0;
                                    n_rx      = 8'd0;
                                end else begin
                                    nxt_phase = PH_IDLE;
                                end
                            end
                            PH_RX_DATA: begin
                                if (r_bit < LAST_BIT) begin
                                    n_rx  = r_rx | (8'(i_req.rx_level) << r_bit[2:0]);
                                    n_bit = bit_inc;
                                end
                                if (n_bit == LAST_BIT) begin
                                    nxt_phase = PH_IDLE;
                                    rx_done   = 1'b1;
                                    n_timer   = 1'b0;
                                end
                            end
                            PH_IDLE: begin
                                if (n_busy) begin
                                    nxt_phase = PH_TX_START;
                                end
                            end
                            PH_TX_START: begin
                                n_line    = 1'b0;
                                n_bit     = 4'd0;
                                nxt_phase = PH_TX_DATA;
                            end
                            PH_TX_DATA: begin
                                if (r_bit < LAST_BIT) begin
                                    n_line = r_rd_data[r_bit[2:0]];
                                end else if (r_bit == LAST_BIT) begin
                                    // Stop bit: retire the byte, drain the buffer when done
                                    n_line    = 1'b1;
                                    n_sent    = sent_inc;
                                    nxt_phase = PH_IDLE;
                                    if (!(r_fill > sent_inc)) begin
                                        n_sent  = '0;
                                        n_fill  = '0;
                                        n_busy  = 1'b0;
                                        n_timer = 1'b0;
                                    end
                                end
                                n_bit = bit_inc;
                            end
                            default: begin
                            end
                        endcase
                        n_phase = nxt_phase;
                    end
                end
                OP_EDGE: begin
                    if (r_phase == PH_IDLE) begin
                        n_timer = 1'b1;
                        n_phase = PH_RX_START;
                    end
                end
                OP_PUSH: begin
                    if (r_fill < DEPTH_C) begin
                        n_timer = 1'b1;
                        n_fill  = r_fill + CW'(1);
                        wr_en   = 1'b1;
                        push_ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= 4'd0;
            r_rx    <= 8'd0;
            r_fill  <= '0;
            r_sent  <= '0;
            r_busy  <= 1'b0;
            r_timer <= 1'b0;
            r_line  <= 1'b1;
        end else begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_rx    <= n_rx;
            r_fill  <= n_fill;
            r_sent  <= n_sent;
            r_busy  <= n_busy;
            r_timer <= n_timer;
            r_line  <= n_line;
        end
    end

    // Transmit buffer: one write port, registered read of the byte being sent
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= i_req.tx_byte;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            r_rd_data <= i_req.tx_byte;
        end else begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    // Form the result from the next state
    always_comb begin
        o_res.tx_line       = n_line;
        o_res.rx_valid      = rx_done;
        o_res.rx_data       = n_rx;
        o_res.push_accepted = push_ok;
        o_res.tx_busy       = n_busy;
        o_res.timer_on      = n_timer;
    end

endmodule
`default_nettype wire

/* rtl/core/hduart_out_skid.sv */
// Output register with skid stage for the result stream.
`default_nettype none
module hduart_out_skid (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  hduart_pkg::t_result i_res,
    output logic                o_ready,
    output logic                o_valid,
    output hduart_pkg::t_result o_res,
    input  wire                 i_ready
);
    import hduart_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;
    logic    accept;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign take    = r_out_valid && i_ready;
    assign accept  = i_valid && !r_skid_valid;

    // Track occupancy of the two slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Move result payloads
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (!r_out_valid || take) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

endmodule
`default_nettype wire
